[design/qapm_pkg.sv]
// Shared widths, constants, payload types and helpers of the attitude PID mixer.
package qapm_pkg;

  localparam int AW = 16;
  localparam int EW = AW + 1;
  localparam int IW = (AW + 2 > 17) ? AW + 2 : 17;
  localparam int DIFF_W = ((AW > 17) ? AW : 18) + 1;
  localparam int DV_W = EW + 1;
  localparam int PK_W = EW + 17;
  localparam int PI_W = IW + 17;
  localparam int PD_W = DV_W + 17;
  localparam int C_W = PI_W + 2;
  localparam int MIX_W = C_W + 3;
  localparam int NUM_AXES = 3;

  localparam logic [10:0] PULSE_MIN = 11'd1000;
  localparam logic [10:0] PULSE_MAX = 11'd2000;
  localparam logic [9:0] PULSE_SPAN = 10'd1000;
  localparam logic [7:0] DUTY_MAX = 8'd255;

  localparam logic [27:0] DIV1000_RECIP = 28'd137438954;
  localparam int DIV1000_SHIFT = 37;

  localparam logic [2:0] REG_GAINS_ROLL = 3'd0;
  localparam logic [2:0] REG_GAINS_PITCH = 3'd1;
  localparam logic [2:0] REG_GAINS_YAW = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_LIMITS = 3'd3;
  localparam logic [2:0] REG_ANGLE_LIMITS = 3'd4;

  typedef struct packed {
    logic armed;
    logic [10:0] throttle_pulse;
    logic [10:0] roll_pulse;
    logic [10:0] pitch_pulse;
    logic [10:0] yaw_pulse;
    logic signed [AW-1:0] roll_meas;
    logic signed [AW-1:0] pitch_meas;
    logic signed [AW-1:0] yaw_meas;
  } in_word_t;

  typedef struct packed {
    logic [7:0] motor_front_right;
    logic [7:0] motor_front_left;
    logic [7:0] motor_rear_left;
    logic [7:0] motor_rear_right;
  } out_word_t;

  typedef struct packed {
    logic advance;
    logic update;
  } lane_ctrl_t;

  function automatic logic [9:0] sat_pulse(input logic [10:0] p);
    logic [9:0] r;
    if (p < PULSE_MIN) begin
      r = '0;
    end else if (p > PULSE_MAX) begin
      r = PULSE_SPAN;
    end else begin
      r = 10'(p - PULSE_MIN);
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_duty(input logic signed [MIX_W-1:0] s);
    logic [7:0] r;
    if (s[MIX_W-1]) begin
      r = '0;
    end else if (|s[MIX_W-2:24]) begin
      r = DUTY_MAX;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

endpackage

[design/qapm_lane.sv]
// One PID lane: stick-to-target mapping, error, clamped integral, derivative and gain sum.
module qapm_lane import qapm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctrl_t              ctrl,
  input  logic [9:0]              pos,
  input  logic signed [AW-1:0]    meas,
  input  logic [15:0]             half,
  input  logic [15:0]             int_lim,
  input  logic [47:0]             gains,
  output logic signed [C_W-1:0]   ctl
);

  logic [26:0] span;
  logic [16:0] quot;
  logic signed [AW-1:0] meas2, meas3;

  logic signed [IW-1:0] integral;
  logic signed [EW-1:0] prev_err;

  logic signed [EW-1:0] err4;
  logic signed [IW-1:0] integ4;
  logic signed [DV_W-1:0] deriv4;

  logic signed [PK_W-1:0] pk;
  logic signed [PI_W-1:0] pi;
  logic signed [PD_W-1:0] pd;

  logic signed [17:0] target;
  logic signed [DIFF_W-1:0] diff;
  logic signed [EW-1:0] err_next;
  logic signed [IW:0] isum, lim_s;
  logic signed [IW-1:0] integral_next;
  logic signed [DV_W-1:0] deriv_next;

  always_comb begin
    target = $signed({1'b0, quot}) - $signed({2'b00, half});
    diff = DIFF_W'(target) - DIFF_W'(meas3);
    if ((&diff[DIFF_W-1:EW-1]) || !(|diff[DIFF_W-1:EW-1])) begin
      err_next = diff[EW-1:0];
    end else if (diff[DIFF_W-1]) begin
      err_next = {1'b1, {(EW-1){1'b0}}};
    end else begin
      err_next = {1'b0, {(EW-1){1'b1}}};
    end
    lim_s = $signed({{(IW+1-16){1'b0}}, int_lim});
    isum = (IW+1)'(integral) + (IW+1)'(err_next);
    if (isum > lim_s) begin
      integral_next = IW'(lim_s);
    end else if (isum < -lim_s) begin
      integral_next = IW'(-lim_s);
    end else begin
      integral_next = IW'(isum);
    end
    deriv_next = DV_W'(err_next) - DV_W'(prev_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (ctrl.update) begin
      integral <= integral_next;
      prev_err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      span <= (27'(pos) * 27'(half)) << 1;
      meas2 <= meas;
      quot <= 17'((55'(span) * 55'(DIV1000_RECIP)) >> DIV1000_SHIFT);
      meas3 <= meas2;
      err4 <= err_next;
      integ4 <= integral_next;
      deriv4 <= deriv_next;
      pk <= PK_W'($signed({1'b0, gains[15:0]})) * PK_W'(err4);
      pi <= PI_W'($signed({1'b0, gains[31:16]})) * PI_W'(integ4);
      pd <= PD_W'($signed({1'b0, gains[47:32]})) * PD_W'(deriv4);
      ctl <= C_W'(pk) + C_W'(pi) + C_W'(pd);
    end
  end

endmodule

[design/qapm_mixer.sv]
// X-frame motor mixer: combines throttle and lane outputs into four clamped duties.
module qapm_mixer import qapm_pkg::*; (
  input  logic                    clk,
  input  lane_ctrl_t              ctrl,
  input  logic                    armed,
  input  logic [7:0]              thr,
  input  logic signed [C_W-1:0]   cr,
  input  logic signed [C_W-1:0]   cp,
  input  logic signed [C_W-1:0]   cy,
  output out_word_t               motors
);

  logic signed [MIX_W-1:0] base;
  logic signed [MIX_W-1:0] spp, spm, bmy, bpy;
  logic [7:0] fr, fl, rl, rr;

  assign base = MIX_W'($signed({1'b0, thr, 16'h0000}));

  always_comb begin
    fr = sat_duty(bmy + spp);
    rl = sat_duty(bmy - spp);
    fl = sat_duty(bpy - spm);
    rr = sat_duty(bpy + spm);
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      spp <= MIX_W'(cr) + MIX_W'(cp);
      spm <= MIX_W'(cr) - MIX_W'(cp);
      bmy <= base - MIX_W'(cy);
      bpy <= base + MIX_W'(cy);
      if (armed) begin
        motors <= '{motor_front_right: fr, motor_front_left: fl,
                    motor_rear_left: rl, motor_rear_right: rr};
      end else begin
        motors <= '0;
      end
    end
  end

endmodule

[design/quad_attitude_pid_mixer_unit.sv]
// Top level of the quadcopter attitude PID controller with X motor mixer.
// Input channel: in_valid / in_stall carry one control tick per word (arm flag,
// four stick pulses, measured roll, pitch and yaw). Output channel: out_valid /
// out_stall carry four motor duties per word, one output word per input word,
// in order. Configuration: cfg_wr_en writes cfg_data to register cfg_index
// (gains roll, pitch, yaw, integral limits, angle limits); other indexes drop.
// Write registers only while no word is in flight.
// Throughput: one word per cycle while the receiver does not stall. The output
// word comes from the eight-stage pipeline whose first stage captures the word
// (pulse mapping, two divide-by-constant multiplies, PID update, gain
// multiplies, lane sum, two mixer stages). The three axis lanes run side by
// side.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; no word is lost.
// Reset clears configuration, integrals and previous errors to zero and empties
// the pipeline. A disarmed word gives zero duties and leaves lane state as is.
module quad_attitude_pid_mixer_unit import qapm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] gains [NUM_AXES];
  logic [47:0] int_limits;
  logic [47:0] angle_limits;

  logic [6:0] vld;
  logic [6:0] arm;
  logic advance;
  lane_ctrl_t ctrl;

  logic [9:0] pt;
  logic [17:0] tprod;
  logic [7:0] thr3, thr4, thr5, thr6;

  logic [9:0] pos [NUM_AXES];
  logic signed [AW-1:0] meas [NUM_AXES];
  logic signed [C_W-1:0] ctl [NUM_AXES];

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign ctrl = '{advance: advance, update: advance && vld[2] && arm[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      gains[0] <= '0;
      gains[1] <= '0;
      gains[2] <= '0;
      int_limits <= '0;
      angle_limits <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAINS_ROLL:      gains[0] <= cfg_data;
        REG_GAINS_PITCH:     gains[1] <= cfg_data;
        REG_GAINS_YAW:       gains[2] <= cfg_data;
        REG_INTEGRAL_LIMITS: int_limits <= cfg_data;
        REG_ANGLE_LIMITS:    angle_limits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      vld <= {vld[5:0], in_valid};
      out_valid <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      arm <= {arm[5:0], in_data.armed};
      pt <= sat_pulse(in_data.throttle_pulse);
      pos[0] <= sat_pulse(in_data.roll_pulse);
      pos[1] <= sat_pulse(in_data.pitch_pulse);
      pos[2] <= sat_pulse(in_data.yaw_pulse);
      meas[0] <= in_data.roll_meas;
      meas[1] <= in_data.pitch_meas;
      meas[2] <= in_data.yaw_meas;
      tprod <= 18'(pt) * 18'(DUTY_MAX);
      thr3 <= 8'((46'(tprod) * 46'(DIV1000_RECIP)) >> DIV1000_SHIFT);
      thr4 <= thr3;
      thr5 <= thr4;
      thr6 <= thr5;
    end
  end

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    qapm_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .pos     (pos[k]),
      .meas    (meas[k]),
      .half    (angle_limits[16*k +: 16]),
      .int_lim (int_limits[16*k +: 16]),
      .gains   (gains[k]),
      .ctl     (ctl[k])
    );
  end

  qapm_mixer u_mixer (
    .clk    (clk),
    .ctrl   (ctrl),
    .armed  (arm[6]),
    .thr    (thr6),
    .cr     (ctl[0]),
    .cp     (ctl[1]),
    .cy     (ctl[2]),
    .motors (out_data)
  );

endmodule

[dv/quad_attitude_pid_mixer_unit_tb.sv]
// Testbench for the attitude PID mixer: predicts motor duties per control tick and checks them.
`timescale 1ns / 100ps

module quad_attitude_pid_mixer_unit_tb;
  import qapm_pkg::*;

  localparam int NUM_REGS = 5;
  localparam int LONG_HOLD = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_TICKS = 200;
  localparam longint ERR_MAX = (longint'(1) << (EW - 1)) - 1;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  logic [47:0] regs_mirror [NUM_REGS] = '{default: '0};
  longint integ_acc [NUM_AXES] = '{default: 0};
  longint last_err [NUM_AXES] = '{default: 0};
  out_word_t expected_duties [$];
  int fail_cnt = 0;
  int idle_cycles = 0;
  rx_mode_t rx_mode = RX_FREE;
  bit tx_gaps = 1'b0;

  quad_attitude_pid_mixer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint pulse_offset(logic [10:0] p);
    if (p < PULSE_MIN) return 0;
    if (p > PULSE_MAX) return 1000;
    return longint'(p) - 1000;
  endfunction

  function automatic longint lane_effort(int ax, logic [10:0] pulse, logic signed [AW-1:0] meas);
    longint half, tgt, err, lim, integ, effort;
    logic [47:0] g;
    half = longint'(regs_mirror[REG_ANGLE_LIMITS][16*ax +: 16]);
    lim = longint'(regs_mirror[REG_INTEGRAL_LIMITS][16*ax +: 16]);
    g = regs_mirror[ax];
    tgt = pulse_offset(pulse) * 2 * half / 1000 - half;
    err = clamp_l(tgt - longint'(meas), -ERR_MAX - 1, ERR_MAX);
    integ = clamp_l(integ_acc[ax] + err, -lim, lim);
    effort = longint'(g[15:0]) * err + longint'(g[31:16]) * integ
           + longint'(g[47:32]) * (err - last_err[ax]);
    integ_acc[ax] = integ;
    last_err[ax] = err;
    return effort;
  endfunction

  function automatic logic [7:0] to_duty(longint s);
    if (s < 0) return 8'd0;
    if ((s >>> 16) > 255) return 8'd255;
    return 8'(s >>> 16);
  endfunction

  function automatic out_word_t predict_duties(in_word_t w);
    out_word_t d;
    longint base, cr, cp, cy;
    d = '0;
    if (!w.armed) return d;
    base = (pulse_offset(w.throttle_pulse) * 255 / 1000) * 65536;
    cr = lane_effort(0, w.roll_pulse, w.roll_meas);
    cp = lane_effort(1, w.pitch_pulse, w.pitch_meas);
    cy = lane_effort(2, w.yaw_pulse, w.yaw_meas);
    d.motor_front_right = to_duty(base + cr + cp - cy);
    d.motor_front_left = to_duty(base - cr + cp + cy);
    d.motor_rear_left = to_duty(base - cr - cp - cy);
    d.motor_rear_right = to_duty(base + cr - cp + cy);
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t tick(bit armed, int t, int r, int p, int y,
                                    int rm, int pm, int ym);
    in_word_t w;
    w.armed = armed;
    w.throttle_pulse = 11'(t);
    w.roll_pulse = 11'(r);
    w.pitch_pulse = 11'(p);
    w.yaw_pulse = 11'(y);
    w.roll_meas = AW'(rm);
    w.pitch_meas = AW'(pm);
    w.yaw_meas = AW'(ym);
    return w;
  endfunction

  function automatic logic [10:0] rand_pulse();
    if ($urandom_range(0, 99) < 85) return 11'($urandom_range(1000, 2000));
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic signed [AW-1:0] rand_angle(bit wild);
    if (wild || $urandom_range(0, 19) == 0) return AW'($urandom);
    return AW'(int'($urandom_range(0, 20480)) - 10240);
  endfunction

  function automatic in_word_t rand_tick(bit wild);
    in_word_t w;
    w.armed = ($urandom_range(0, 9) != 0);
    w.throttle_pulse = rand_pulse();
    w.roll_pulse = rand_pulse();
    w.pitch_pulse = rand_pulse();
    w.yaw_pulse = rand_pulse();
    w.roll_meas = rand_angle(wild);
    w.pitch_meas = rand_angle(wild);
    w.yaw_meas = rand_angle(wild);
    return w;
  endfunction

  function automatic logic [47:0] rand_gains(bit tame);
    if (tame) begin
      return {16'($urandom_range(0, 1023)), 16'($urandom_range(0, 127)),
              16'($urandom_range(0, 1023))};
    end
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] rand_lims(int hi);
    return {16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)),
            16'($urandom_range(0, hi))};
  endfunction

  function automatic void check_duty(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx < NUM_REGS) regs_mirror[idx] = val;
  endtask

  task automatic load_settings(logic [47:0] gr, logic [47:0] gp, logic [47:0] gy,
                               logic [47:0] ilim, logic [47:0] alim);
    write_reg(REG_GAINS_ROLL, gr);
    write_reg(REG_GAINS_PITCH, gp);
    write_reg(REG_GAINS_YAW, gy);
    write_reg(REG_INTEGRAL_LIMITS, ilim);
    write_reg(REG_ANGLE_LIMITS, alim);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    expected_duties.push_back(predict_duties(w));
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_disarmed();
    send_tick(tick(0, 2047, 0, 2047, 0, -32768, 32767, 0));
    send_tick(tick(1, 1000, 1500, 1500, 1500, 0, 0, 0));
    send_tick(tick(1, 2000, 1500, 1500, 1500, 0, 0, 0));
    send_tick(tick(1, 1500, 1000, 2000, 1500, 100, -100, 0));
    send_tick(tick(1, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(1, 2047, 2047, 2047, 2047, -1, -1, -1));
    drain_results();
  endtask

  task automatic test_limits();
    load_settings(48'h0100_0100_0100, 48'h0100_0100_0100, 48'h0100_0100_0100,
                  48'h0040_0040_0040, '1);
    repeat (3) send_tick(tick(1, 1500, 2000, 1000, 999, -32768, 32767, 0));
    send_tick(tick(0, 1500, 1500, 1500, 1500, 0, 0, 0));
    send_tick(tick(1, 1500, 2001, 2047, 0, 0, 0, 32767));
    send_tick(tick(1, 1500, 1000, 2000, 2000, 32767, -32768, -32768));
    drain_results();
    load_settings(48'h0080_0010_0100, 48'h0080_0010_0100, 48'h0040_0008_0080,
                  48'h0200_0200_0200, 48'h0A00_0A00_0A00);
    send_tick(tick(1, 1500, 1500, 1500, 1500, 256, -256, 512));
    send_tick(tick(1, 1500, 1600, 1400, 1500, 0, 0, 0));
    send_tick(tick(1, 1300, 1400, 1600, 1700, -512, 384, 0));
    drain_results();
    for (int i = NUM_REGS; i < (1 << $bits(cfg_index)); i++) write_reg(3'(i), '1);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_tick(tick(1, 1500, 1550, 1450, 1500, 128, -128, 64));
    send_tick(tick(1, 1700, 1500, 1500, 1300, 0, 0, -256));
    drain_results();
    load_settings('1, '1, '1, '1, '1);
    send_tick(tick(1, 2000, 2000, 1000, 1500, 0, 0, 0));
    send_tick(tick(1, 1000, 1000, 2000, 1500, 0, 0, 0));
    send_tick(tick(1, 1500, 1500, 1500, 1500, -32768, 32767, -1));
    drain_results();
  endtask

  task automatic test_random_flight();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_settings(rand_gains(1), rand_gains(1), rand_gains(1),
                         rand_lims(4096), rand_lims(7680));
        1: load_settings(rand_gains(1), rand_gains(1), rand_gains(1),
                         rand_lims(65535), rand_lims(65535));
        2: load_settings(rand_gains(0), rand_gains(0), rand_gains(0),
                         rand_lims(65535), rand_lims(65535));
        3: load_settings(rand_gains(1), rand_gains(1), rand_gains(1),
                         rand_lims(4096), rand_lims(7680));
        default: load_settings(rand_gains(1), rand_gains(1), rand_gains(1),
                               rand_lims(2048), rand_lims(7680));
      endcase
      rx_mode <= (ph == 4) ? RX_FREE : RX_RANDOM;
      tx_gaps = (ph != 4);
      repeat (PHASE_TICKS) send_tick(rand_tick(ph == 3));
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    load_settings(rand_gains(1), rand_gains(1), rand_gains(1),
                  rand_lims(4096), rand_lims(7680));
    rx_mode <= RX_HOLD;
    tx_gaps = 1'b0;
    repeat (180) send_tick(rand_tick(0));
    drain_results();
  endtask

  always begin
    int n;
    @(posedge clk);
    if (rx_mode == RX_HOLD) begin
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      out_stall <= 1'b0;
      rx_mode <= RX_RANDOM;
    end else if (rx_mode == RX_RANDOM) begin
      n = pick_gap();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_duties.size() == 0) begin
        $error("output word with no expected duties: %h", out_data);
        fail_cnt++;
      end else begin
        want = expected_duties.pop_front();
        check_duty("motor_front_right", want.motor_front_right, out_data.motor_front_right);
        check_duty("motor_front_left", want.motor_front_left, out_data.motor_front_left);
        check_duty("motor_rear_left", want.motor_rear_left, out_data.motor_rear_left);
        check_duty("motor_rear_right", want.motor_rear_right, out_data.motor_rear_right);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_disarmed();
    test_limits();
    test_random_flight();
    test_backpressure();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && expected_duties.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
